FILE: rtl/mtma_pkg.sv
// Shared types and defaults for the median-then-moving-average filter.
// No dependencies; every module of the filter imports this package.
package mtma_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int MEDIAN_TAPS_DEF   = 3;
  localparam int AVG_TAPS_DEF      = 5;
  localparam int QUEUE_DEPTH       = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // One beat between front, queue and back.
  typedef struct packed {
    logic    vld;
    sample_t med;
  } med_beat_t;

endpackage

FILE: rtl/mtma_front.sv
// Front end: accepts samples, keeps the circular median window, ranks it.
// Depends on mtma_pkg.
module mtma_front #(
  parameter int MEDIAN_TAPS = mtma_pkg::MEDIAN_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtma_pkg::sample_t   in_sample,
  input  logic                q_ready,
  output mtma_pkg::med_beat_t push
);
  import mtma_pkg::*;

  localparam int SLOT_W = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int RANK_W = $clog2(MEDIAN_TAPS);
  localparam int MID    = MEDIAN_TAPS / 2;

  sample_t           win_r   [MEDIAN_TAPS];
  sample_t           win_nxt [MEDIAN_TAPS];
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  sample_t           med;
  logic              accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // Rank every entry; ties break by position, so ranks form a permutation.
  always_comb begin
    logic [RANK_W-1:0] rank;
    med = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      win_nxt[i] = (slot_r == SLOT_W'(i)) ? in_sample : win_r[i];
    end
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i) begin
          if ((win_nxt[j] < win_nxt[i]) || ((win_nxt[j] == win_nxt[i]) && (j < i))) begin
            rank = rank + RANK_W'(1);
          end
        end
      end
      if (rank == RANK_W'(MID)) begin
        med = win_nxt[i];
      end
    end
  end

  assign slot_nxt = (slot_r == SLOT_W'(MEDIAN_TAPS - 1)) ? '0 : slot_r + SLOT_W'(1);

  assign push.vld = accept;
  assign push.med = med;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (accept) begin
      slot_r <= slot_nxt;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

FILE: rtl/mtma_queue.sv
// Two-entry queue that decouples the median front end from the averaging back end.
// Depends on mtma_pkg.
module mtma_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mtma_pkg::med_beat_t push,
  output logic                q_ready,
  output mtma_pkg::med_beat_t head,
  input  logic                pop
);
  import mtma_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sample_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_ready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head.vld = (count_r != '0);
  assign head.med = mem_r[rd_ptr_r];

  assign do_push = push.vld && q_ready;
  assign do_pop  = pop && head.vld;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.med;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

FILE: rtl/mtma_back.sv
// Back end: circular averaging window, running sum, reciprocal divide, output register.
// Depends on mtma_pkg.
module mtma_back #(
  parameter int AVG_TAPS = mtma_pkg::AVG_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mtma_pkg::med_beat_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mtma_pkg::sample_t   out_filtered
);
  import mtma_pkg::*;

  localparam int SLOT_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(AVG_TAPS);
  // Exact floor division for any SUM_W-bit dividend by multiply and shift.
  localparam int SHIFT  = SUM_W + $clog2(AVG_TAPS);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [63:0] RCP_WIDE = ((64'd1 << SHIFT) + 64'(AVG_TAPS) - 64'd1)
                                     / 64'(AVG_TAPS);
  localparam logic [RCP_W-1:0] RCP = RCP_WIDE[RCP_W-1:0];

  sample_t           win_r [AVG_TAPS];
  logic [SLOT_W-1:0] slot_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              sum_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_vld_r;
  logic              out_load;

  // Advance the sum stage into the output register when it is free or drains.
  assign out_load = sum_vld_r && (!out_vld_r || out_ready);
  assign pop      = head.vld && (!sum_vld_r || out_load);

  assign sum_nxt = sum_r - {{(SUM_W - SAMPLE_W){1'b0}}, win_r[slot_r]}
                         + {{(SUM_W - SAMPLE_W){1'b0}}, head.med};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      sum_r     <= '0;
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < AVG_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        win_r[slot_r] <= head.med;
        sum_r         <= sum_nxt;
        slot_r        <= (slot_r == SLOT_W'(AVG_TAPS - 1)) ? '0 : slot_r + SLOT_W'(1);
        sum_vld_r     <= 1'b1;
      end else if (out_load) begin
        sum_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prod_r <= {{RCP_W{1'b0}}, sum_r} * {{SUM_W{1'b0}}, RCP};
    end
  end

  assign out_valid    = out_vld_r;
  assign out_filtered = prod_r[SHIFT +: SAMPLE_W];

endmodule

FILE: rtl/median_then_moving_average_filter.sv
// Median-then-moving-average filter: top level.
// Path: an accepted sample passes the queue, the running-sum and the output (divide) registers.
// Throughput: one sample per cycle while out_ready stays high; the running-sum update
//   and the rank network of the median window are each combinational.
// Reset: synchronous, active low rst_n clears both windows, slots, the running sum,
//   the queue and all valid flags, so outputs ramp up from zero.
module median_then_moving_average_filter #(
  parameter int MEDIAN_TAPS = mtma_pkg::MEDIAN_TAPS_DEF,
  parameter int AVG_TAPS    = mtma_pkg::AVG_TAPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtma_pkg::sample_t in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output mtma_pkg::sample_t out_filtered
);
  import mtma_pkg::*;

  // Beats from the front end into the queue, and the queue head toward the back end.
  med_beat_t push;
  med_beat_t head;
  logic      q_ready;
  logic      pop;

  // Front: take a beat whenever the queue has room, drop the sample into the
  // median window and rank the window with the new sample in place.
  mtma_front #(
    .MEDIAN_TAPS (MEDIAN_TAPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_ready   (q_ready),
    .push      (push)
  );

  // Queue: hold medians so that a stall on the output does not stall the front
  // until both entries fill.
  mtma_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .head    (head),
    .pop     (pop)
  );

  // Back: advance the averaging window and running sum, then divide by the
  // tap count with a reciprocal multiply into the output register.
  mtma_back #(
    .AVG_TAPS (AVG_TAPS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

endmodule
